>>> sv/crlfd_pkg.sv
package crlfd_pkg;

    // Line terminator bytes.
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Line limit register.
    localparam int unsigned LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] MIN_LIMIT   = 7'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Default depth of the line store.
    localparam int unsigned LINE_DEPTH_DEF = 64;

    // Result kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_OVF  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;       // store the input byte and update the CR flag
        logic clr;      // drop the pending line
        logic rd;       // read the store at the readout index
        logic ld_byte;  // load a line byte into the output register
        logic ld_ovf;   // load an overflow result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ovf;      // pending line is full
        logic crlf;     // input byte is an LF right after a CR
        logic rd_last;  // readout index is on the last byte of the line
        logic out_free; // output register can take a result this cycle
    } t_sts;

endpackage

>>> sv/crlf_line_deframer_core.sv
// A byte that does not end a line or overflow is taken without a stall.
// An overflowing byte is taken and drops the line; its result waits in an overflow
// state for a free output register. Input stalls from the closing LF while the line
// is read out through the single store read port, a read then a load state per byte.
// Reset is synchronous and active low: it clears the pending line, the CR flag,
// the output valid flag, and sets line_limit to 64; the line store is not cleared.
module crlf_line_deframer_core #(
    parameter int unsigned LINE_DEPTH = crlfd_pkg::LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [crlfd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last
);

    crlfd_pkg::t_cmd cmd;
    crlfd_pkg::t_sts sts;

    // Sequencer for accept, readout and overflow.
    crlfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Line store, counters and output register.
    crlfd_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (i_in_byte),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

`ifndef NO_ASSERTIONS
    // The final byte of a line shows up as a last line-byte beat.
    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.ld_byte && sts.rd_last) |=> (o_out_valid && o_last && !o_kind))
        else $error("line end not flagged on output");

    // An overflow gives a single zero beat marked last.
    a_ovf_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ld_ovf |=> (o_out_valid && o_kind && o_last && (o_out_byte == 8'h00)))
        else $error("malformed overflow beat");

    // No byte is taken while the store is being read out.
    a_no_accept_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rd || cmd.ld_byte) |-> o_in_stall)
        else $error("input taken during line readout");
`endif

endmodule

>>> sv/crlfd_ctrl.sv
module crlfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  crlfd_pkg::t_sts   i_sts,
    output logic              o_in_stall,
    output crlfd_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_OVF  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Bytes are taken only while no line readout or overflow is in progress.
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.ovf) begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_OVF;
                    end else begin
                        o_cmd.wr = 1'b1;
                        if (i_sts.crlf) begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_byte = 1'b1;
                    if (i_sts.rd_last) begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_OVF: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_ovf = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/crlfd_dp.sv
module crlfd_dp #(
    parameter int unsigned LINE_DEPTH = crlfd_pkg::LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [crlfd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_out_stall,
    input  crlfd_pkg::t_cmd               i_cmd,
    output crlfd_pkg::t_sts               o_sts,
    output logic                          o_out_valid,
    output logic                          o_kind,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last
);

    localparam int unsigned FW = $clog2(LINE_DEPTH + 1);
    localparam int unsigned AW = $clog2(LINE_DEPTH);
    localparam int unsigned LW = crlfd_pkg::LIMIT_W;
    localparam logic [LW-1:0] DEPTH_LIM = LW'(LINE_DEPTH);

    logic [LW-1:0] r_limit;
    logic [LW-1:0] lim_eff;
    logic [FW-1:0] r_fill;
    logic          r_cr;
    logic [AW-1:0] r_rd_idx;
    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rdata;
    logic          r_out_valid;
    logic          r_kind;
    logic [7:0]    r_out_byte;
    logic          r_last;

    // Limit register keeps the written bits; the clamp is applied on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= crlfd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_limit < crlfd_pkg::MIN_LIMIT) begin
            lim_eff = crlfd_pkg::MIN_LIMIT;
        end else if (r_limit > DEPTH_LIM) begin
            lim_eff = DEPTH_LIM;
        end else begin
            lim_eff = r_limit;
        end
    end

    // Status toward the controller.
    assign o_sts.ovf      = (LW'(r_fill) >= lim_eff);
    assign o_sts.crlf     = (i_in_byte == crlfd_pkg::BYTE_LF) && r_cr;
    assign o_sts.rd_last  = ((FW'(r_rd_idx) + FW'(1)) == r_fill);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Fill count, CR flag and readout index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_cr     <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_fill <= '0;
                r_cr   <= 1'b0;
            end else if (i_cmd.wr) begin
                r_fill <= r_fill + FW'(1);
                r_cr   <= (i_in_byte == crlfd_pkg::BYTE_CR);
            end
            if (i_cmd.wr) begin
                r_rd_idx <= '0;
            end else if (i_cmd.ld_byte) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
        end
    end

    // Line store: one write port at the fill position, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_fill[AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_rd_idx];
        end
    end

    // Output register: valid is control, the payload is loaded with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_byte || i_cmd.ld_ovf) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_byte) begin
            r_kind     <= crlfd_pkg::KIND_BYTE;
            r_out_byte <= r_rdata;
            r_last     <= o_sts.rd_last;
        end else if (i_cmd.ld_ovf) begin
            r_kind     <= crlfd_pkg::KIND_OVF;
            r_out_byte <= 8'h00;
            r_last     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

endmodule
